### src/mcq_pkg.sv
package mcq_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int NUM_ACTIONS_DEF = 15;

    localparam int BTN_W = 16;
    localparam int ACT_W = 15;

    localparam logic [15:0] GRACE_RESET = 16'd64;

    // physical button and semantic action positions
    localparam logic [3:0] BTN_RB            = 4'd6;
    localparam logic [4:0] ACT_CATEGORY_NEXT = 5'd9;

    // scope codes
    localparam logic [1:0] SCOPE_NONE    = 2'd0;
    localparam logic [1:0] SCOPE_INVALID = 2'd3;

    // query codes
    localparam logic [2:0] QUERY_NONE = 3'd0;
    localparam logic [2:0] QUERY_EAST = 3'd2;
    localparam logic [2:0] QUERY_DOWN = 3'd6;

    // configuration register indexes
    localparam logic CFG_SWAP_ACCEPT_BACK = 1'b0;
    localparam logic CFG_GRACE_TICKS      = 1'b1;

    typedef struct packed {
        logic [31:0]      now;
        logic             active;
        logic             capture_all;
        logic [1:0]       scope;
        logic [2:0]       query_action;
        logic [ACT_W-1:0] consumed_mask;
        logic [BTN_W-1:0] down_mask;
        logic [BTN_W-1:0] pressed_mask;
        logic [BTN_W-1:0] released_mask;
    } frame_t;

    typedef struct packed {
        logic             chord_fired;
        logic [BTN_W-1:0] blocked_mask;
        logic             is_armed;
        logic             lock_held;
    } result_t;

    typedef struct packed {
        logic             armed;
        logic [1:0]       armed_in_scope;
        logic [31:0]      grace_deadline;
        logic             grace_valid;
        logic             waiting_release;
        logic             release_seen;
        logic [BTN_W-1:0] lock_buttons;
    } chord_state_t;

    typedef struct packed {
        logic        swap_accept_back;
        logic [15:0] grace_ticks;
    } cfg_t;

endpackage

### src/mcq_step.sv
module mcq_step #(
    parameter int NUM_BUTTONS = mcq_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_ACTIONS = mcq_pkg::NUM_ACTIONS_DEF
) (
    input  mcq_pkg::frame_t       frame,
    input  mcq_pkg::chord_state_t state,
    input  mcq_pkg::cfg_t         cfg,
    output mcq_pkg::chord_state_t state_next,
    output mcq_pkg::result_t      result
);

    localparam int BTN_KEEP = (NUM_BUTTONS < mcq_pkg::BTN_W) ? NUM_BUTTONS : mcq_pkg::BTN_W;
    localparam int ACT_KEEP = (NUM_ACTIONS < mcq_pkg::ACT_W) ? NUM_ACTIONS : mcq_pkg::ACT_W;
    localparam logic [32:0] BTN_MASK_W = (33'd1 << BTN_KEEP) - 33'd1;
    localparam logic [32:0] ACT_MASK_W = (33'd1 << ACT_KEEP) - 33'd1;
    localparam logic [mcq_pkg::BTN_W-1:0] BTN_MASK = BTN_MASK_W[mcq_pkg::BTN_W-1:0];
    localparam logic [mcq_pkg::ACT_W-1:0] ACT_MASK = ACT_MASK_W[mcq_pkg::ACT_W-1:0];

    // actions past the configured count always read as consumed
    function automatic logic act_consumed(input logic [mcq_pkg::ACT_W-1:0] mask,
                                          input logic [4:0] idx);
        logic hit;
        hit = 1'b0;
        if (32'(idx) >= NUM_ACTIONS) begin
            hit = 1'b1;
        end else if (32'(idx) < mcq_pkg::ACT_W) begin
            hit = mask[idx[3:0]];
        end
        return hit;
    endfunction

    mcq_pkg::chord_state_t s;
    logic [mcq_pkg::ACT_W-1:0] consumed;
    logic [mcq_pkg::BTN_W-1:0] down;
    logic [mcq_pkg::BTN_W-1:0] pressed;
    logic [mcq_pkg::BTN_W-1:0] released;
    logic [1:0]  scope_eff;
    logic [31:0] deadline_diff;
    logic        reached_old;
    logic        reached;
    logic [2:0]  act;
    logic [3:0]  btn;
    logic        avail;
    logic        blocked;
    logic        fired;

    assign deadline_diff = frame.now - state.grace_deadline;
    assign reached_old   = ~deadline_diff[31];

    always_comb
    begin
        s         = state;
        consumed  = frame.consumed_mask & ACT_MASK;
        down      = frame.down_mask & BTN_MASK;
        pressed   = frame.pressed_mask & BTN_MASK;
        released  = frame.released_mask & BTN_MASK;
        reached   = reached_old;
        fired     = 1'b0;
        act       = frame.query_action - 3'd1;
        btn       = {1'b0, act};
        avail     = 1'b0;
        blocked   = 1'b0;

        // release tracking
        if (!frame.active)
        begin
            s.armed       = 1'b0;
            s.grace_valid = 1'b0;
        end
        if (s.waiting_release)
        begin
            if (s.release_seen)
            begin
                s.waiting_release = 1'b0;
                s.armed           = 1'b0;
                s.armed_in_scope  = mcq_pkg::SCOPE_NONE;
                s.grace_valid     = 1'b0;
                s.lock_buttons    = '0;
                s.release_seen    = 1'b0;
            end else if ((s.lock_buttons & down) == '0)
            begin
                s.release_seen = 1'b1;
            end
        end

        // scope declaration
        if (!frame.active || frame.scope == mcq_pkg::SCOPE_INVALID)
        begin
            scope_eff = mcq_pkg::SCOPE_NONE;
        end else
        begin
            scope_eff = frame.scope;
        end
        if (!s.waiting_release)
        begin
            if (scope_eff == mcq_pkg::SCOPE_NONE)
            begin
                s.armed          = 1'b0;
                s.armed_in_scope = mcq_pkg::SCOPE_NONE;
                s.grace_valid    = 1'b0;
            end else if (pressed[mcq_pkg::BTN_RB])
            begin
                s.armed          = 1'b1;
                s.armed_in_scope = scope_eff;
                s.grace_valid    = 1'b0;
            end else if (s.armed && s.armed_in_scope == scope_eff)
            begin
                if (down[mcq_pkg::BTN_RB])
                begin
                    s.grace_valid = 1'b0;
                end else
                begin
                    if (released[mcq_pkg::BTN_RB] && !s.grace_valid)
                    begin
                        s.grace_deadline = frame.now + {16'd0, cfg.grace_ticks};
                        s.grace_valid    = 1'b1;
                        // a fresh deadline is already reached only for a zero window
                        reached          = (cfg.grace_ticks == 16'd0);
                    end
                    if (s.grace_valid && reached)
                    begin
                        s.armed          = 1'b0;
                        s.armed_in_scope = mcq_pkg::SCOPE_NONE;
                        s.grace_valid    = 1'b0;
                    end
                end
            end
        end

        // capture
        if (frame.capture_all)
        begin
            consumed      = ACT_MASK;
            s.armed       = 1'b0;
            s.grace_valid = 1'b0;
        end

        // query
        if (frame.query_action != mcq_pkg::QUERY_NONE && frame.query_action <= mcq_pkg::QUERY_DOWN
            && s.armed && !s.waiting_release && scope_eff != mcq_pkg::SCOPE_NONE
            && scope_eff == s.armed_in_scope)
        begin
            avail   = down[mcq_pkg::BTN_RB] || (s.grace_valid && !reached);
            blocked = act_consumed(consumed, mcq_pkg::ACT_CATEGORY_NEXT)
                      || act_consumed(consumed, {2'b00, act})
                      || (frame.query_action <= mcq_pkg::QUERY_EAST && cfg.swap_accept_back
                          && act_consumed(consumed, {2'b00, act ^ 3'd1}));
            if (avail && !blocked && pressed[btn])
            begin
                s.lock_buttons    = ((mcq_pkg::BTN_W'(1) << mcq_pkg::BTN_RB)
                                     | (mcq_pkg::BTN_W'(1) << btn)) & BTN_MASK;
                s.waiting_release = 1'b1;
                s.armed           = 1'b0;
                s.grace_valid     = 1'b0;
                s.release_seen    = 1'b0;
                fired             = 1'b1;
            end
        end
    end

    assign state_next          = s;
    assign result.chord_fired  = fired;
    assign result.blocked_mask = s.waiting_release ? s.lock_buttons : '0;
    assign result.is_armed     = s.armed;
    assign result.lock_held    = s.waiting_release;

endmodule

### src/modifier_chord_qualifier_top.sv
// the result is registered and is valid after the edge that accepts its frame
// throughput: one frame per cycle; the chord state and the result register update together
// at the accepting edge, and a frame is taken whenever the result register is empty or
// its transaction completes in the same cycle
// reset (rst_n low, asynchronous): chord state cleared, no result pending,
// swap_accept_back 0 and grace_ticks 64
module modifier_chord_qualifier_top #(
    parameter int NUM_BUTTONS = mcq_pkg::NUM_BUTTONS_DEF,
    parameter int NUM_ACTIONS = mcq_pkg::NUM_ACTIONS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_ready,
    input  mcq_pkg::frame_t  frame,
    output logic             result_valid,
    input  logic             result_ready,
    output mcq_pkg::result_t result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data
);

    mcq_pkg::chord_state_t state_reg;
    mcq_pkg::chord_state_t state_next;
    mcq_pkg::cfg_t         cfg_reg;
    mcq_pkg::result_t      result_reg;
    mcq_pkg::result_t      result_next;
    logic                  result_valid_reg;
    logic                  frame_take;

    assign frame_ready = !result_valid_reg || result_ready;
    assign frame_take  = frame_valid && frame_ready;

    mcq_step #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .NUM_ACTIONS(NUM_ACTIONS)
    ) u_step (
        .frame     (frame),
        .state     (state_reg),
        .cfg       (cfg_reg),
        .state_next(state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swap_accept_back <= 1'b0;
            cfg_reg.grace_ticks      <= mcq_pkg::GRACE_RESET;
        end else if (cfg_we)
        begin
            case (cfg_index)
                mcq_pkg::CFG_SWAP_ACCEPT_BACK: cfg_reg.swap_accept_back <= cfg_data[0];
                mcq_pkg::CFG_GRACE_TICKS:      cfg_reg.grace_ticks      <= cfg_data;
                default:                       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end else
        begin
            if (frame_take)
            begin
                state_reg <= state_next;
            end
            if (frame_take)
            begin
                result_valid_reg <= 1'b1;
            end else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the lock always covers the modifier, so a held lock never shows an empty mask
    a_lock_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.lock_held == (result.blocked_mask != '0)))
        else $error("lock_held and blocked_mask disagree");

    a_armed_not_locked: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.armed && state_reg.waiting_release))
        else $error("armed while waiting for release");

    a_grace_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.grace_valid |-> state_reg.armed)
        else $error("grace window open while disarmed");

    a_fire_locks: assert property (@(posedge clk) disable iff (!rst_n)
        frame_take && result_next.chord_fired |=> state_reg.waiting_release && !state_reg.armed
                                                  && state_reg.lock_buttons[mcq_pkg::BTN_RB])
        else $error("fired transaction did not take the lock");

endmodule
